[sv/obstacle_turn_controller_core_defines.svh]
// ----------------------------------------------------------------------------
// Obstacle turn controller assertion macros
// Shared property macros for the concurrent checks of the controller core.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_TURN_CONTROLLER_CORE_DEFINES_SVH
`define OBSTACLE_TURN_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define OTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("otc: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define OTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("otc: next-cycle check failed");

`endif

[sv/otc_pkg.sv]
// ----------------------------------------------------------------------------
// Obstacle turn controller package
// Widths, register indexes, drive constants and shared types.
// ----------------------------------------------------------------------------
package otc_pkg;

  localparam int unsigned DIST_W     = 10;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned STREAK_W   = 2;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;

  // Register indexes on the configuration channel.
  localparam logic [CFG_ADDR_W-1:0] REG_TURN_ENTER   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TURN_EXIT    = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STRONG_EXIT  = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_OPEN    = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BALANCE_BAND = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_TURN     = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD         = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PWM_MAX      = 4'd7;

  // Drive constants.
  localparam logic [STREAK_W-1:0] STREAK_NEEDED    = 2'd2;
  localparam logic [STREAK_W-1:0] STREAK_SAT       = 2'd3;
  localparam logic [DUTY_W-1:0]   CRUISE_DUTY      = 16'd350;
  localparam logic [DUTY_W-1:0]   PIVOT_OUTER_DUTY = 16'd380;
  localparam logic [DUTY_W-1:0]   PIVOT_INNER_DUTY = 16'd360;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } otc_dir_e;

  typedef struct packed {
    logic [DIST_W-1:0] turn_enter_cm;
    logic [DIST_W-1:0] turn_exit_cm;
    logic [DIST_W-1:0] strong_exit_cm;
    logic [DIST_W-1:0] side_open_cm;
    logic [DIST_W-1:0] balance_band_cm;
    logic [MS_W-1:0]   min_turn_ms;
    logic [MS_W-1:0]   hold_ms;
    logic [DUTY_W-1:0] pwm_max;
  } otc_cfg_t;

  localparam otc_cfg_t CFG_RESET = '{
    turn_enter_cm:   10'd40,
    turn_exit_cm:    10'd46,
    strong_exit_cm:  10'd51,
    side_open_cm:    10'd30,
    balance_band_cm: 10'd8,
    min_turn_ms:     16'd170,
    hold_ms:         16'd120,
    pwm_max:         16'd999
  };

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [DIST_W-1:0] left_dist;
    logic [DIST_W-1:0] right_dist;
    logic [DIST_W-1:0] front_dist;
  } otc_frame_t;

  typedef struct packed {
    logic                turning;
    otc_dir_e            turn_direction;
    logic [TIME_W-1:0]   turn_deadline;
    logic [TIME_W-1:0]   hold_until;
    logic [STREAK_W-1:0] clear_streak;
    logic [STREAK_W-1:0] balance_streak;
  } otc_state_t;

  localparam otc_state_t STATE_RESET = '{
    turning:        1'b0,
    turn_direction: DIR_NONE,
    turn_deadline:  '0,
    hold_until:     '0,
    clear_streak:   '0,
    balance_streak: '0
  };

  typedef struct packed {
    logic              drive_issued;
    logic              left_reverse;
    logic              right_reverse;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              mode_after;
    otc_dir_e          direction_after;
  } otc_result_t;

endpackage

[sv/obstacle_turn_controller_core.sv]
// ----------------------------------------------------------------------------
// Obstacle turn controller core
// Cruise and pivot-turn decision for one sensor frame per word.
// ----------------------------------------------------------------------------
// The slave stream takes one frame per word: the millisecond time and the
// filtered left, right and front distances. The master stream returns one
// word per frame with the wheel directions, the clamped PWM duties and the
// mode and turn direction after the frame; tuser flags whether the frame
// issued a drive command at all (mode-change frames do not).
// A frame is held in an input register, decided by short combinational logic
// against the controller state, and the result lands in an output register,
// which drives tvalid on the master side. While the receiver keeps up, the
// block sustains one word per cycle. The controller state is updated in the
// same edge that loads the output register.
// When the receiver stalls, the output word holds and the input register
// still takes one more frame before tready drops.
// Reset returns the thresholds to their defaults, puts the block in cruise
// mode with clear streaks and timers, and empties both registers.
// The configuration channel is always ready; it is meant to be written only
// while no frame is in flight.
// ----------------------------------------------------------------------------
`include "obstacle_turn_controller_core_defines.svh"

module obstacle_turn_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [otc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [otc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Frame input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: now_ms[31:0], left_dist[41:32], right_dist[51:42],
  // front_dist[61:52], zero[63:62]
  input  logic [otc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Result output stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: left_reverse[0], right_reverse[1], left_duty[17:2],
  // right_duty[33:18], mode_after[34], direction_after[36:35], zero[39:37]
  output logic [otc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: drive_issued[0]
  output logic                           m_axis_tuser_o
);
  import otc_pkg::*;

  otc_cfg_t    cfg;
  otc_frame_t  in_frame_q, in_frame_d;
  logic        in_valid_q, in_valid_d;
  otc_result_t out_result_q, dec_result;
  logic        out_valid_q, out_valid_d;
  otc_state_t  state_q, state_d;
  logic        in_accept;
  logic        out_load;

  otc_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // The output register loads whenever the input register holds a frame and the
  // output one is empty or being drained, so the input register frees up in the same cycle.
  assign out_load        = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || out_load;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_frame_d.now_ms     = s_axis_tdata_i[31:0];
    in_frame_d.left_dist  = s_axis_tdata_i[41:32];
    in_frame_d.right_dist = s_axis_tdata_i[51:42];
    in_frame_d.front_dist = s_axis_tdata_i[61:52];
  end

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (out_load) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  otc_decide u_decide (
    .frame_i  (in_frame_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .result_o (dec_result),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_frame_q <= in_frame_d;
    end
    if (out_load) begin
      out_result_q <= dec_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_result_q.drive_issued;
  assign m_axis_tdata_o  = {3'b000,
                            out_result_q.direction_after,
                            out_result_q.mode_after,
                            out_result_q.right_duty,
                            out_result_q.left_duty,
                            out_result_q.right_reverse,
                            out_result_q.left_reverse};

  // The reported mode always matches the state left behind by that frame.
  `OTC_ASSERT_NEXT(a_mode_tracks_state, clk_i, rst_ni, out_load,
    out_result_q.mode_after == state_q.turning)

  // A word that issues no drive command carries zero directions and duties.
  `OTC_ASSERT_NOW(a_no_drive_is_zero, clk_i, rst_ni,
    out_valid_q && !out_result_q.drive_issued,
    (out_result_q.left_duty == '0) && (out_result_q.right_duty == '0) &&
    !out_result_q.left_reverse && !out_result_q.right_reverse)

  // Turning always has a direction, cruising never has one.
  `OTC_ASSERT_NOW(a_mode_dir_agree, clk_i, rst_ni, out_valid_q,
    out_result_q.mode_after == (out_result_q.direction_after != DIR_NONE))

endmodule

[sv/otc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Obstacle turn controller configuration registers
// Holds the eight thresholds and limits, written one word at a time.
// ----------------------------------------------------------------------------
module otc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [otc_pkg::CFG_ADDR_W-1:0] wr_addr_i,
  input  logic [otc_pkg::CFG_DATA_W-1:0] wr_data_i,
  output otc_pkg::otc_cfg_t              cfg_o
);
  import otc_pkg::*;

  otc_cfg_t cfg_q, cfg_d;

  // Distance registers keep the low bits of the word only.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_addr_i)
        REG_TURN_ENTER:   cfg_d.turn_enter_cm   = wr_data_i[DIST_W-1:0];
        REG_TURN_EXIT:    cfg_d.turn_exit_cm    = wr_data_i[DIST_W-1:0];
        REG_STRONG_EXIT:  cfg_d.strong_exit_cm  = wr_data_i[DIST_W-1:0];
        REG_SIDE_OPEN:    cfg_d.side_open_cm    = wr_data_i[DIST_W-1:0];
        REG_BALANCE_BAND: cfg_d.balance_band_cm = wr_data_i[DIST_W-1:0];
        REG_MIN_TURN:     cfg_d.min_turn_ms     = wr_data_i[MS_W-1:0];
        REG_HOLD:         cfg_d.hold_ms         = wr_data_i[MS_W-1:0];
        REG_PWM_MAX:      cfg_d.pwm_max         = wr_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/otc_decide.sv]
// ----------------------------------------------------------------------------
// Obstacle turn controller decision logic
// Computes one frame's drive command and the next controller state.
// ----------------------------------------------------------------------------
module otc_decide (
  input  otc_pkg::otc_frame_t  frame_i,
  input  otc_pkg::otc_state_t  state_i,
  input  otc_pkg::otc_cfg_t    cfg_i,
  output otc_pkg::otc_result_t result_o,
  output otc_pkg::otc_state_t  state_o
);
  import otc_pkg::*;

  // A deadline is still ahead when the wrapped distance to it is nonzero
  // and below half the time range.
  function automatic logic still_pending(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] gap;
    gap = deadline - now;
    return (gap != '0) && !gap[TIME_W-1];
  endfunction

  function automatic logic [STREAK_W-1:0] bump(input logic [STREAK_W-1:0] cnt,
                                               input logic                cond);
    logic [STREAK_W-1:0] res;
    if (!cond) begin
      res = '0;
    end else if (cnt != STREAK_SAT) begin
      res = cnt + STREAK_W'(1);
    end else begin
      res = STREAK_SAT;
    end
    return res;
  endfunction

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] val,
                                                   input logic [DUTY_W-1:0] lim);
    return (val > lim) ? lim : val;
  endfunction

  logic [DIST_W-1:0]   abs_diff;
  logic [STREAK_W-1:0] clear_next;
  logic [STREAK_W-1:0] balance_next;
  logic                exit_turn;
  logic                enter_turn;
  logic                left_avail;
  logic                right_avail;

  always_comb begin
    abs_diff = (frame_i.left_dist >= frame_i.right_dist) ?
               (frame_i.left_dist - frame_i.right_dist) :
               (frame_i.right_dist - frame_i.left_dist);
    clear_next   = bump(state_i.clear_streak, frame_i.front_dist >= cfg_i.turn_exit_cm);
    balance_next = bump(state_i.balance_streak,
                        (abs_diff <= cfg_i.balance_band_cm) &&
                        (frame_i.front_dist >= cfg_i.turn_enter_cm));
    exit_turn  = (frame_i.front_dist >= cfg_i.strong_exit_cm) ||
                 (balance_next >= STREAK_NEEDED) ||
                 ((clear_next >= STREAK_NEEDED) &&
                  !still_pending(frame_i.now_ms, state_i.turn_deadline));
    enter_turn = !still_pending(frame_i.now_ms, state_i.hold_until) &&
                 (frame_i.front_dist <= cfg_i.turn_enter_cm);
    left_avail  = frame_i.left_dist >= cfg_i.side_open_cm;
    right_avail = frame_i.right_dist >= cfg_i.side_open_cm;

    state_o  = state_i;
    result_o = '0;

    if (state_i.turning) begin
      if (exit_turn) begin
        state_o.turning        = 1'b0;
        state_o.turn_direction = DIR_NONE;
        state_o.hold_until     = frame_i.now_ms + TIME_W'(cfg_i.hold_ms);
        state_o.clear_streak   = '0;
        state_o.balance_streak = '0;
      end else begin
        state_o.clear_streak   = clear_next;
        state_o.balance_streak = balance_next;
        result_o.drive_issued  = 1'b1;
        // Anything other than a left turn pivots right.
        if (state_i.turn_direction == DIR_LEFT) begin
          result_o.left_reverse = 1'b1;
          result_o.left_duty    = clamp_duty(PIVOT_INNER_DUTY, cfg_i.pwm_max);
          result_o.right_duty   = clamp_duty(PIVOT_OUTER_DUTY, cfg_i.pwm_max);
        end else begin
          result_o.right_reverse = 1'b1;
          result_o.left_duty     = clamp_duty(PIVOT_OUTER_DUTY, cfg_i.pwm_max);
          result_o.right_duty    = clamp_duty(PIVOT_INNER_DUTY, cfg_i.pwm_max);
        end
      end
    end else if (enter_turn) begin
      // Head for the only open side, else the farther one; ties go left.
      if (left_avail != right_avail) begin
        state_o.turn_direction = left_avail ? DIR_LEFT : DIR_RIGHT;
      end else begin
        state_o.turn_direction = (frame_i.left_dist >= frame_i.right_dist) ?
                                 DIR_LEFT : DIR_RIGHT;
      end
      state_o.turning        = 1'b1;
      state_o.turn_deadline  = frame_i.now_ms + TIME_W'(cfg_i.min_turn_ms);
      state_o.clear_streak   = '0;
      state_o.balance_streak = '0;
    end else begin
      result_o.drive_issued = 1'b1;
      result_o.left_duty    = clamp_duty(CRUISE_DUTY, cfg_i.pwm_max);
      result_o.right_duty   = clamp_duty(CRUISE_DUTY, cfg_i.pwm_max);
    end

    result_o.mode_after      = state_o.turning;
    result_o.direction_after = state_o.turn_direction;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Obstacle turn controller core testbench
// Streams sensor frames through the core under several threshold settings,
// predicts every drive command in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
// A directed opening walks through turn entry toward each side, the tie rule,
// every way out of a turn, the re-entry hold and a millisecond wrap. After
// that, episodes of approach, turn and clearance frames with random content
// are mixed with noise frames. Between phases the stream is drained and the
// registers are rewritten, including the extremes, a stray index and values
// with junk above the register width. Both sides of the stream stall at
// random but in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import otc_pkg::*;

  localparam int unsigned NUM_REGS       = 8;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum {SEG_APPROACH, SEG_TURN, SEG_CLEAR, SEG_NOISE} segment_e;

  typedef struct {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // Predicts the drive command of every frame and holds the ones not yet seen.
  class turn_scoreboard;
    otc_cfg_t    cfg;
    otc_state_t  st;
    otc_result_t command_q[$];
    int unsigned errors;

    function new();
      cfg    = CFG_RESET;
      st     = STATE_RESET;
      errors = 0;
    endfunction

    function int unsigned pending();
      return command_q.size();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_TURN_ENTER:   cfg.turn_enter_cm   = data[DIST_W-1:0];
        REG_TURN_EXIT:    cfg.turn_exit_cm    = data[DIST_W-1:0];
        REG_STRONG_EXIT:  cfg.strong_exit_cm  = data[DIST_W-1:0];
        REG_SIDE_OPEN:    cfg.side_open_cm    = data[DIST_W-1:0];
        REG_BALANCE_BAND: cfg.balance_band_cm = data[DIST_W-1:0];
        REG_MIN_TURN:     cfg.min_turn_ms     = data;
        REG_HOLD:         cfg.hold_ms         = data;
        REG_PWM_MAX:      cfg.pwm_max         = data;
        default: ;
      endcase
    endfunction

    // A deadline counts as running while it lies less than half the time
    // range ahead, so the millisecond wrap is harmless.
    function bit still_running(logic [TIME_W-1:0] now, logic [TIME_W-1:0] deadline);
      logic [TIME_W-1:0] gap;
      gap = deadline - now;
      return (gap != '0) && !gap[TIME_W-1];
    endfunction

    function logic [DUTY_W-1:0] clamp_duty(logic [DUTY_W-1:0] duty);
      return (duty > cfg.pwm_max) ? cfg.pwm_max : duty;
    endfunction

    function logic [STREAK_W-1:0] bump(logic [STREAK_W-1:0] count, bit hit);
      if (!hit) return '0;
      return (count == STREAK_SAT) ? count : count + STREAK_W'(1);
    endfunction

    function void frame_accepted(otc_frame_t f);
      otc_result_t      cmd;
      logic [DIST_W-1:0] side_gap;
      bit               instant_exit, balance_exit, clear_exit;
      bit               left_avail, right_avail;
      cmd = '0;
      if (st.turning) begin
        side_gap = (f.left_dist >= f.right_dist) ? f.left_dist - f.right_dist
                                                 : f.right_dist - f.left_dist;
        st.clear_streak   = bump(st.clear_streak, f.front_dist >= cfg.turn_exit_cm);
        st.balance_streak = bump(st.balance_streak,
                                 side_gap <= cfg.balance_band_cm &&
                                 f.front_dist >= cfg.turn_enter_cm);
        instant_exit = f.front_dist >= cfg.strong_exit_cm;
        balance_exit = st.balance_streak >= STREAK_NEEDED;
        clear_exit   = st.clear_streak >= STREAK_NEEDED &&
                       !still_running(f.now_ms, st.turn_deadline);
        if (instant_exit || balance_exit || clear_exit) begin
          // Leaving the turn issues no drive command this frame.
          st.turning        = 1'b0;
          st.turn_direction = DIR_NONE;
          st.hold_until     = f.now_ms + TIME_W'(cfg.hold_ms);
          st.clear_streak   = '0;
          st.balance_streak = '0;
        end else begin
          cmd.drive_issued = 1'b1;
          if (st.turn_direction == DIR_LEFT) begin
            cmd.left_reverse = 1'b1;
            cmd.left_duty    = clamp_duty(PIVOT_INNER_DUTY);
            cmd.right_duty   = clamp_duty(PIVOT_OUTER_DUTY);
          end else begin
            cmd.right_reverse = 1'b1;
            cmd.left_duty     = clamp_duty(PIVOT_OUTER_DUTY);
            cmd.right_duty    = clamp_duty(PIVOT_INNER_DUTY);
          end
        end
      end else if (!still_running(f.now_ms, st.hold_until) &&
                   f.front_dist <= cfg.turn_enter_cm) begin
        // Turn toward the only open side, else toward the farther one.
        left_avail  = f.left_dist >= cfg.side_open_cm;
        right_avail = f.right_dist >= cfg.side_open_cm;
        if (left_avail != right_avail) begin
          st.turn_direction = left_avail ? DIR_LEFT : DIR_RIGHT;
        end else begin
          st.turn_direction = (f.left_dist >= f.right_dist) ? DIR_LEFT : DIR_RIGHT;
        end
        st.turning        = 1'b1;
        st.turn_deadline  = f.now_ms + TIME_W'(cfg.min_turn_ms);
        st.clear_streak   = '0;
        st.balance_streak = '0;
      end else begin
        cmd.drive_issued = 1'b1;
        cmd.left_duty    = clamp_duty(CRUISE_DUTY);
        cmd.right_duty   = clamp_duty(CRUISE_DUTY);
      end
      cmd.mode_after      = st.turning;
      cmd.direction_after = st.turn_direction;
      command_q.push_back(cmd);
    endfunction

    function void compare(string field, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_command(logic [OUT_DATA_W-1:0] data, logic user);
      otc_result_t want;
      if (command_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual tdata=%h tuser=%b",
                 $time, data, user);
        errors++;
        return;
      end
      want = command_q.pop_front();
      compare("drive_issued", want.drive_issued, user);
      compare("left_reverse", want.left_reverse, data[0]);
      compare("right_reverse", want.right_reverse, data[1]);
      compare("left_duty", want.left_duty, data[17:2]);
      compare("right_duty", want.right_duty, data[33:18]);
      compare("mode_after", want.mode_after, data[34]);
      compare("direction_after", want.direction_after, data[36:35]);
      compare("tdata padding", '0, data[39:37]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_valid   = 1'b0;
  logic [IN_DATA_W-1:0]  s_data    = '0;
  logic                  m_ready   = 1'b0;
  logic                  cfg_ready;
  logic                  s_ready;
  logic                  m_valid;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  m_user;

  turn_scoreboard sb = new();
  reg_write_t     write_q[$];
  logic [TIME_W-1:0] clock_ms = '0;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  int unsigned    quiet_cycles = 0;

  obstacle_turn_controller_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stalls at random at the current rate.
  always @(posedge clk) begin
    m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Monitor and watchdog. Results are checked before the frame of the same
  // edge is noted, since a result always belongs to an older frame.
  always @(posedge clk) begin
    otc_frame_t f;
    if (rst_n && m_valid && m_ready) begin
      sb.check_command(m_data, m_user);
    end
    if (rst_n && s_valid && s_ready) begin
      f.now_ms     = s_data[31:0];
      f.left_dist  = s_data[41:32];
      f.right_dist = s_data[51:42];
      f.front_dist = s_data[61:52];
      sb.frame_accepted(f);
    end
    if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_frame(input otc_frame_t f);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {2'b00, f.front_dist, f.right_dist, f.left_dist, f.now_ms};
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic send(input logic [TIME_W-1:0] now, input logic [DIST_W-1:0] left,
                      input logic [DIST_W-1:0] right, input logic [DIST_W-1:0] front);
    otc_frame_t f;
    clock_ms = now;
    f = '{now_ms: now, left_dist: left, right_dist: right, front_dist: front};
    send_frame(f);
  endtask

  // Holds the sender back until every predicted command has come out.
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic flush_writes();
    reg_write_t w;
    while (write_q.size() != 0) begin
      w = write_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_addr  <= w.addr;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(w.addr, w.data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic stage_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
    write_q.push_back('{addr: addr, data: data});
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] enter, exit_clear, exit_now,
                                input logic [CFG_DATA_W-1:0] side, band, min_turn, hold,
                                input logic [CFG_DATA_W-1:0] pwm);
    stage_write(REG_TURN_ENTER, enter);
    stage_write(REG_TURN_EXIT, exit_clear);
    stage_write(REG_STRONG_EXIT, exit_now);
    stage_write(REG_SIDE_OPEN, side);
    stage_write(REG_BALANCE_BAND, band);
    stage_write(REG_MIN_TURN, min_turn);
    stage_write(REG_HOLD, hold);
    stage_write(REG_PWM_MAX, pwm);
  endtask

  // A write to an index past the last register must change nothing.
  task automatic stage_stray_write();
    stage_write(CFG_ADDR_W'($urandom_range(NUM_REGS, 2**CFG_ADDR_W - 1)),
                CFG_DATA_W'($urandom()));
  endtask

  function automatic logic [DIST_W-1:0] near(input logic [DIST_W-1:0] center,
                                             input int unsigned spread);
    int v;
    v = int'(center) - int'(spread) + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > int'(DIST_MAX)) v = int'(DIST_MAX);
    return DIST_W'(v);
  endfunction

  function automatic otc_frame_t next_frame(input segment_e seg);
    otc_frame_t  f;
    int unsigned pick;
    int          offset;
    pick = $urandom_range(0, 99);
    if (seg == SEG_NOISE && pick < 50) begin
      clock_ms = $urandom();
    end else if (pick < 70) begin
      clock_ms += $urandom_range(0, 30);
    end else if (pick < 95) begin
      clock_ms += $urandom_range(30, 250);
    end else begin
      clock_ms += $urandom_range(250, 70000);
    end
    f.now_ms = clock_ms;

    pick = $urandom_range(0, 99);
    case (seg)
      SEG_APPROACH: f.front_dist = near(sb.cfg.turn_enter_cm, 6);
      SEG_TURN: begin
        if (pick < 40)      f.front_dist = near(sb.cfg.turn_exit_cm, 4);
        else if (pick < 65) f.front_dist = near(sb.cfg.turn_enter_cm, 4);
        else if (pick < 80) f.front_dist = near(sb.cfg.strong_exit_cm, 3);
        else                f.front_dist = DIST_W'($urandom());
      end
      SEG_CLEAR: begin
        if (pick < 50) f.front_dist = near(sb.cfg.strong_exit_cm, 4);
        else           f.front_dist = DIST_W'($urandom());
      end
      default: f.front_dist = DIST_W'($urandom());
    endcase

    // Sides: a pair near the balance band in half the turn frames, else around
    // the open threshold or anywhere.
    pick = $urandom_range(0, 99);
    if (seg == SEG_TURN && pick < 50) begin
      f.left_dist = DIST_W'($urandom());
      offset      = int'($urandom_range(0, int'(sb.cfg.balance_band_cm) + 2));
      if ($urandom_range(0, 1) != 0) offset = -offset;
      f.right_dist = near(DIST_W'(int'(f.left_dist) + offset > int'(DIST_MAX) ?
                                  int'(DIST_MAX) : (int'(f.left_dist) + offset < 0 ?
                                  0 : int'(f.left_dist) + offset)), 0);
    end else if (seg != SEG_NOISE && pick < 75) begin
      f.left_dist  = near(sb.cfg.side_open_cm, 5);
      f.right_dist = near(sb.cfg.side_open_cm, 5);
    end else begin
      f.left_dist  = DIST_W'($urandom());
      f.right_dist = DIST_W'($urandom());
    end
    return f;
  endfunction

  // Episodes of approach, turn and clearance frames, with noise in between.
  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_frame(next_frame(SEG_NOISE));
        sent++;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) send_frame(next_frame(SEG_APPROACH));
        sent += k;
        k = $urandom_range(1, 6);
        repeat (k) send_frame(next_frame(SEG_TURN));
        sent += k;
        k = $urandom_range(0, 3);
        repeat (k) send_frame(next_frame(SEG_CLEAR));
        sent += k;
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    int unsigned enter_cm, exit_cm;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 26;
    rx_idle_pct = 61;

    // Directed walk with the reset thresholds.
    send(32'd1000, DIST_MAX, '0, DIST_MAX);       // cruise, field extremes
    send(32'd1010, '0, DIST_MAX, '0);             // only right open: turn right
    send(32'd1020, '0, DIST_MAX, '0);             // pivot right
    send(32'd1030, 10'd500, 10'd500, 10'd51);     // strong clearance ends it
    send(32'd1040, 10'd500, 10'd500, 10'd10);     // re-entry hold still running
    send(32'd1150, 10'd500, 10'd500, 10'd40);     // hold over, both open, tie: left
    send(32'd1160, 10'd300, 10'd100, 10'd46);     // clear streak builds
    send(32'd1170, 10'd300, 10'd100, 10'd46);     // streak met, minimum turn not over
    send(32'd1330, 10'd300, 10'd100, 10'd47);     // streak saturates, minimum over
    send(32'd1460, 10'd10, 10'd20, 10'd30);       // neither open: farther is right
    send(32'd1470, 10'd100, 10'd105, 10'd45);     // balance streak starts
    send(32'd1480, 10'd100, 10'd108, 10'd45);     // balance streak ends the turn
    send(32'd1600, 10'd29, 10'd30, 10'd5);        // right side just open
    send(32'd1610, DIST_MAX, '0, 10'd20);
    send(32'd1620, 10'd200, 10'd600, 10'd50);
    send(32'hFFFF_FFA0, 10'd200, 10'd600, 10'd60); // exit, hold wraps past zero
    send(32'hFFFF_FFF0, 10'd200, 10'd600, '0);     // hold pending across the wrap
    send(32'h0000_0010, 10'd200, 10'd600, '0);
    send(32'h0000_0018, '0, '0, '0);               // hold just over, tie: left
    send(32'h0000_0020, '0, 10'd900, 10'd46);
    send(32'h0000_0030, '0, 10'd900, 10'd46);
    send(32'h0000_00C2, '0, 10'd900, 10'd46);      // minimum turn ends exactly now
    run_traffic(140);
    wait_drained();

    // Narrow duty clamp that cuts the pivot outer duty only.
    set_thresholds(16'd100, 16'd140, 16'd200, 16'd60, 16'd20, 16'd300, 16'd50, 16'd370);
    flush_writes();
    run_traffic(140);
    wait_drained();

    // Low extremes: every duty clamps to zero and no timer holds.
    tx_idle_pct = 61;
    rx_idle_pct = 26;
    set_thresholds('0, '0, '0, '0, '0, '0, '0, '0);
    stage_stray_write();
    flush_writes();
    run_traffic(60);
    wait_drained();

    // High extremes, written with bits above the distance width set.
    set_thresholds('1, '1, '1, '1, '1, '1, '1, '1);
    flush_writes();
    run_traffic(60);
    wait_drained();

    // Random thresholds with junk in the upper bits, then no stalls at all.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    enter_cm = $urandom_range(0, 200);
    exit_cm  = enter_cm + $urandom_range(0, 20);
    stage_stray_write();
    set_thresholds({6'($urandom()), 10'(enter_cm)},
                   {6'($urandom()), 10'(exit_cm)},
                   {6'($urandom()), 10'(exit_cm + $urandom_range(0, 30))},
                   {6'($urandom()), 10'($urandom_range(0, 300))},
                   {6'($urandom()), 10'($urandom_range(0, 40))},
                   16'($urandom_range(0, 600)),
                   16'($urandom_range(0, 400)),
                   16'($urandom_range(340, 400)));
    flush_writes();
    run_traffic(200);
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/otc_pkg.sv
sv/otc_cfg_regs.sv
sv/otc_decide.sv
sv/obstacle_turn_controller_core.sv
tb/tb_top.sv
